// File: hdl/dctcp_pkg.sv
// Shared types and constants of the DCTCP ACK rate controller.
`timescale 1ns / 1ps

package dctcp_pkg;

  localparam int unsigned SeqW   = 32;
  localparam int unsigned RateW  = 20;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned MtuW   = 16;
  localparam int unsigned StepW  = 6;
  localparam int unsigned MulAW  = 20;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned ProdW  = MulAW + MulBW;

  localparam logic [AlphaW-1:0] AlphaOne    = 17'd65536;
  localparam logic [MulBW-1:0]  AlphaTwo    = 18'd131072;
  localparam logic [StepW-1:0]  StepsFrac   = 6'd16;
  localparam logic [StepW-1:0]  StepsBatch  = 6'd32;

  localparam logic [AlphaW-1:0] GainReset   = 17'd4096;
  localparam logic [RateW-1:0]  IncReset    = 20'd1000;
  localparam logic [RateW-1:0]  MinReset    = 20'd100;
  localparam logic [RateW-1:0]  MaxReset    = 20'd100000;
  localparam logic [MtuW-1:0]   MtuReset    = 16'd1000;

  typedef enum logic [2:0] {
    REG_EWMA_GAIN     = 3'd0,
    REG_RATE_INCREASE = 3'd1,
    REG_MIN_RATE      = 3'd2,
    REG_MAX_RATE      = 3'd3,
    REG_MTU_BYTES     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [SeqW-1:0]  rem_init;
    logic [SeqW-1:0]  num;
    logic [SeqW-1:0]  den;
    logic [StepW-1:0] steps;
  } div_req_t;

endpackage

// File: hdl/dctcp_div.sv
// Shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dctcp_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dctcp_pkg::div_req_t    req_i,
  output logic                   done_o,
  output logic [31:0]            quo_o
);
  import dctcp_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [SeqW-1:0]   rem_q, rem_d;
  logic [SeqW-1:0]   num_q, num_d;
  logic [SeqW-1:0]   den_q, den_d;
  logic [SeqW-1:0]   quo_q, quo_d;
  logic [SeqW:0]     trial;
  logic              fits;

  assign trial = {rem_q, num_q[SeqW-1]} - {1'b0, den_q};
  assign fits  = ~trial[SeqW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      num_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? trial[SeqW-1:0] : {rem_q[SeqW-2:0], num_q[SeqW-1]};
      num_d = {num_q[SeqW-2:0], 1'b0};
      quo_d = {quo_q[SeqW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/dctcp_mul.sv
// Registered multiplier shared by the alpha update and the rate cut.
`timescale 1ns / 1ps

module dctcp_mul (
  input  logic                          clk_i,
  input  logic [dctcp_pkg::MulAW-1:0]   a_i,
  input  logic [dctcp_pkg::MulBW-1:0]   b_i,
  output logic [dctcp_pkg::ProdW-1:0]   prod_o
);
  import dctcp_pkg::*;

  logic [ProdW-1:0] prod_q, prod_d;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/dctcp_ack_rate_control.sv
// Top level of the DCTCP ACK rate controller: sequencer, state and register port.
// Each ACK runs PREP, WIN, CUT when a cut applies, and FIN; the first batch to close adds
// the batch divide (BATCH) before WIN, and a later closing batch adds the fraction divide
// (FRAC), the alpha update (MUL1 to MUL3) and BATCH. FIN holds while the output stalls.
// One ACK at a time: the next is taken the cycle after its result loads in FIN.
// Reset: asynchronous, active low; registers and state return to their defaults.
`timescale 1ns / 1ps

module dctcp_ack_rate_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] ack_sequence_i,
  input  logic        congestion_mark_i,
  input  logic [31:0] send_next_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] current_rate_o,
  output logic [16:0] alpha_now_o,
  output logic        in_reduction_o,
  output logic        batch_closed_o
);
  import dctcp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_FRAC  = 10'b0000000100,
    S_MUL1  = 10'b0000001000,
    S_MUL2  = 10'b0000010000,
    S_MUL3  = 10'b0000100000,
    S_BATCH = 10'b0001000000,
    S_WIN   = 10'b0010000000,
    S_CUT   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;

  logic [AlphaW-1:0] gain_q;
  logic [RateW-1:0]  inc_q, min_q, max_q;
  logic [MtuW-1:0]   mtu_q;

  logic [RateW-1:0]  rate_q, rate_d;
  logic [AlphaW-1:0] alpha_q, alpha_d;
  logic [SeqW-1:0]   mc_q, mc_d;
  logic [SeqW-1:0]   upd_q, upd_d;
  logic [SeqW-1:0]   bp_q, bp_d;
  logic              rw_q, rw_d;
  logic [SeqW-1:0]   whs_q, whs_d;

  logic [SeqW-1:0]   ack_q, ack_d;
  logic [SeqW-1:0]   snd_q, snd_d;
  logic              mark_q, mark_d;
  logic              closed_q, closed_d;
  logic              first_q, first_d;
  logic              sat_q, sat_d;
  logic [AlphaW-1:0] frac_q, frac_d;
  logic [32:0]       acc_q, acc_d;

  logic              ov_q, ov_d;
  logic [RateW-1:0]  o_rate_q, o_rate_d;
  logic [AlphaW-1:0] o_alpha_q, o_alpha_d;
  logic              o_red_q, o_red_d;
  logic              o_closed_q, o_closed_d;

  div_req_t          div_req;
  logic              div_done;
  logic [SeqW-1:0]   div_quo;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  mul_prod;

  logic              wr_en;
  logic [2:0]        reg_idx;
  logic              accept;
  logic [AlphaW-1:0] gain_eff;
  logic [SeqW-1:0]   mtu_eff;
  logic [SeqW-1:0]   bp_eff;
  logic [32:0]       alpha_sum;
  logic              rw_eff;
  logic [RateW:0]    rate_sum;
  logic [RateW-1:0]  cut;

  // Register port
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_comb begin
    case (reg_idx)
      REG_EWMA_GAIN:     prdata = 32'(gain_q);
      REG_RATE_INCREASE: prdata = 32'(inc_q);
      REG_MIN_RATE:      prdata = 32'(min_q);
      REG_MAX_RATE:      prdata = 32'(max_q);
      REG_MTU_BYTES:     prdata = 32'(mtu_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      inc_q  <= IncReset;
      min_q  <= MinReset;
      max_q  <= MaxReset;
      mtu_q  <= MtuReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_EWMA_GAIN:     gain_q <= pwdata[AlphaW-1:0];
        REG_RATE_INCREASE: inc_q  <= pwdata[RateW-1:0];
        REG_MIN_RATE:      min_q  <= pwdata[RateW-1:0];
        REG_MAX_RATE:      max_q  <= pwdata[RateW-1:0];
        REG_MTU_BYTES:     mtu_q  <= pwdata[MtuW-1:0];
        default: ;
      endcase
    end
  end

  // Shared units
  dctcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  dctcp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  assign gain_eff  = (gain_q > AlphaOne) ? AlphaOne : gain_q;
  assign mtu_eff   = (mtu_q == '0) ? 32'd1 : 32'(mtu_q);
  assign bp_eff    = (bp_q == '0) ? 32'd1 : bp_q;
  assign alpha_sum = acc_q + mul_prod[32:0];
  assign rw_eff    = rw_q & ~(ack_q > whs_q);
  assign rate_sum  = {1'b0, rate_q} + {1'b0, inc_q};
  assign cut       = mul_prod[RateW+16:17];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL1: begin
        mul_a = MulAW'(AlphaOne - gain_eff);
        mul_b = MulBW'(alpha_q);
      end
      S_MUL2: begin
        mul_a = MulAW'(gain_eff);
        mul_b = MulBW'(frac_q);
      end
      S_WIN: begin
        mul_a = rate_q;
        mul_b = AlphaTwo - MulBW'(alpha_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    rate_d     = rate_q;
    alpha_d    = alpha_q;
    mc_d       = mc_q;
    upd_d      = upd_q;
    bp_d       = bp_q;
    rw_d       = rw_q;
    whs_d      = whs_q;
    ack_d      = ack_q;
    snd_d      = snd_q;
    mark_d     = mark_q;
    closed_d   = closed_q;
    first_d    = first_q;
    sat_d      = sat_q;
    frac_d     = frac_q;
    acc_d      = acc_q;
    ov_d       = ov_q & out_stall_i;
    o_rate_d   = o_rate_q;
    o_alpha_d  = o_alpha_q;
    o_red_d    = o_red_q;
    o_closed_d = o_closed_q;
    div_req    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ack_d    = ack_sequence_i;
          snd_d    = send_next_i;
          mark_d   = congestion_mark_i;
          closed_d = ack_sequence_i > upd_q;
          first_d  = (upd_q == '0);
          if (congestion_mark_i && (mc_q != '1)) begin
            mc_d = mc_q + 1'b1;
          end
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (!closed_q) begin
          state_d = S_WIN;
        end else if (first_q) begin
          div_req = '{start: 1'b1, rem_init: '0, num: snd_q, den: mtu_eff,
                      steps: StepsBatch};
          state_d = S_BATCH;
        end else begin
          sat_d   = (mc_q >= bp_eff);
          div_req = '{start: 1'b1, rem_init: (mc_q >= bp_eff) ? '0 : mc_q,
                      num: '0, den: bp_eff, steps: StepsFrac};
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        if (div_done) begin
          frac_d  = sat_q ? AlphaOne : {1'b0, div_quo[15:0]};
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = mul_prod[32:0];
        state_d = S_MUL3;
      end
      S_MUL3: begin
        alpha_d = alpha_sum[32:16];
        mc_d    = '0;
        div_req = '{start: 1'b1, rem_init: '0, num: snd_q - ack_q, den: mtu_eff,
                    steps: StepsBatch};
        state_d = S_BATCH;
      end
      S_BATCH: begin
        if (div_done) begin
          upd_d   = snd_q;
          bp_d    = (div_quo == '1) ? div_quo : div_quo + 1'b1;
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        rw_d = rw_eff;
        if (mark_q && !rw_eff) begin
          state_d = S_CUT;
        end else begin
          if (!rw_eff && closed_q) begin
            rate_d = (rate_sum > {1'b0, max_q}) ? max_q : rate_sum[RateW-1:0];
          end
          state_d = S_FIN;
        end
      end
      S_CUT: begin
        rate_d  = (cut < min_q) ? min_q : cut;
        rw_d    = 1'b1;
        whs_d   = snd_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!ov_q || !out_stall_i) begin
          ov_d       = 1'b1;
          o_rate_d   = rate_q;
          o_alpha_d  = alpha_q;
          o_red_d    = rw_q;
          o_closed_d = closed_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rate_q  <= MaxReset;
      alpha_q <= AlphaOne;
      mc_q    <= '0;
      upd_q   <= '0;
      bp_q    <= 32'd1;
      rw_q    <= 1'b0;
      whs_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rate_q  <= rate_d;
      alpha_q <= alpha_d;
      mc_q    <= mc_d;
      upd_q   <= upd_d;
      bp_q    <= bp_d;
      rw_q    <= rw_d;
      whs_q   <= whs_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q      <= ack_d;
    snd_q      <= snd_d;
    mark_q     <= mark_d;
    closed_q   <= closed_d;
    first_q    <= first_d;
    sat_q      <= sat_d;
    frac_q     <= frac_d;
    acc_q      <= acc_d;
    o_rate_q   <= o_rate_d;
    o_alpha_q  <= o_alpha_d;
    o_red_q    <= o_red_d;
    o_closed_q <= o_closed_d;
  end

  assign out_valid_o    = ov_q;
  assign current_rate_o = o_rate_q;
  assign alpha_now_o    = o_alpha_q;
  assign in_reduction_o = o_red_q;
  assign batch_closed_o = o_closed_q;

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_FRAC || state_q == S_BATCH))
    else $error("divider finished outside a divide step");

  a_alpha_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= AlphaOne)
    else $error("alpha above one");

  a_window_opens_on_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rw_q) |-> $past(mark_q) && $past(state_q == S_CUT))
    else $error("reduction window opened without a marked request");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_PREP)
    else $error("accepted request did not start the sequencer");

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the DCTCP ACK rate controller: directed table, random flows.
`timescale 1ns / 1ps

module testbench;
  import dctcp_pkg::*;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 222;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned TailCycles    = 64;
  localparam logic [2:0]  UnmappedIdx   = 3'd5;

  typedef struct packed {
    logic [RateW-1:0]  rate;
    logic [AlphaW-1:0] alpha;
    logic              window;
    logic              closed;
  } rate_result_t;

  typedef enum logic {ROW_ACK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [31:0]  a;
    logic         mark;
    logic [31:0]  b;
    logic         has_want;
    rate_result_t want;
  } stim_row_t;

  localparam stim_row_t Directed [34] = '{
    '{ROW_ACK, 32'd0, 1'b0, 32'd0, 1'b1, '{20'd100000, 17'd65536, 1'b0, 1'b0}},
    '{ROW_ACK, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, '{20'd100000, 17'd65536, 1'b0, 1'b0}},
    '{ROW_ACK, 32'd1, 1'b1, 32'd10000, 1'b1, '{20'd50000, 17'd65536, 1'b1, 1'b1}},
    '{ROW_ACK, 32'd20000, 1'b0, 32'd30000, 1'b0, '0},
    '{ROW_ACK, 32'd25000, 1'b1, 32'd40000, 1'b0, '0},
    '{ROW_ACK, 32'd40001, 1'b0, 32'd40001, 1'b0, '0},
    '{ROW_ACK, 32'd40002, 1'b1, 32'd40002, 1'b0, '0},
    '{ROW_ACK, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_CFG, 32'(REG_EWMA_GAIN), 1'b0, 32'd131071, 1'b0, '0},
    '{ROW_CFG, 32'(REG_MTU_BYTES), 1'b0, 32'd0, 1'b0, '0},
    '{ROW_CFG, 32'(REG_MIN_RATE), 1'b0, 32'd1000000, 1'b0, '0},
    '{ROW_CFG, 32'(REG_MAX_RATE), 1'b0, 32'd1, 1'b0, '0},
    '{ROW_CFG, 32'(REG_RATE_INCREASE), 1'b0, 32'd1000000, 1'b0, '0},
    '{ROW_CFG, 32'(UnmappedIdx), 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_ACK, 32'd1, 1'b0, 32'd2, 1'b0, '0},
    '{ROW_ACK, 32'd5, 1'b0, 32'd4, 1'b0, '0},
    '{ROW_ACK, 32'd6, 1'b1, 32'd100, 1'b1, '{20'd1000000, 17'd0, 1'b1, 1'b1}},
    '{ROW_ACK, 32'd100, 1'b0, 32'd200, 1'b0, '0},
    '{ROW_ACK, 32'd101, 1'b0, 32'd300, 1'b1, '{20'd1, 17'd0, 1'b0, 1'b1}},
    '{ROW_CFG, 32'(REG_MAX_RATE), 1'b0, 32'd1000000, 1'b0, '0},
    '{ROW_CFG, 32'(REG_MIN_RATE), 1'b0, 32'd0, 1'b0, '0},
    '{ROW_CFG, 32'(REG_EWMA_GAIN), 1'b0, 32'd0, 1'b0, '0},
    '{ROW_CFG, 32'(REG_RATE_INCREASE), 1'b0, 32'd0, 1'b0, '0},
    '{ROW_CFG, 32'(REG_MTU_BYTES), 1'b0, 32'd65535, 1'b0, '0},
    '{ROW_ACK, 32'd101, 1'b1, 32'd500, 1'b1, '{20'd1, 17'd0, 1'b1, 1'b0}},
    '{ROW_ACK, 32'd301, 1'b0, 32'd70000, 1'b0, '0},
    '{ROW_ACK, 32'd600, 1'b1, 32'd600, 1'b0, '0},
    '{ROW_ACK, 32'd70001, 1'b0, 32'hFFFF_0000, 1'b0, '0},
    '{ROW_ACK, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, '0},
    '{ROW_CFG, 32'(REG_EWMA_GAIN), 1'b0, 32'(GainReset), 1'b0, '0},
    '{ROW_CFG, 32'(REG_RATE_INCREASE), 1'b0, 32'(IncReset), 1'b0, '0},
    '{ROW_CFG, 32'(REG_MIN_RATE), 1'b0, 32'(MinReset), 1'b0, '0},
    '{ROW_CFG, 32'(REG_MAX_RATE), 1'b0, 32'(MaxReset), 1'b0, '0},
    '{ROW_CFG, 32'(REG_MTU_BYTES), 1'b0, 32'(MtuReset), 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] ack_sequence_i = '0;
  logic        congestion_mark_i = 1'b0;
  logic [31:0] send_next_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [19:0] current_rate_o;
  logic [16:0] alpha_now_o;
  logic        in_reduction_o;
  logic        batch_closed_o;

  logic [AlphaW-1:0] cfg_gain = GainReset;
  logic [RateW-1:0]  cfg_inc  = IncReset;
  logic [RateW-1:0]  cfg_min  = MinReset;
  logic [RateW-1:0]  cfg_max  = MaxReset;
  logic [MtuW-1:0]   cfg_mtu  = MtuReset;

  logic [RateW-1:0]  p_rate        = MaxReset;
  logic [AlphaW-1:0] p_alpha       = AlphaOne;
  logic [31:0]       p_marks       = '0;
  logic [31:0]       p_update_seq  = '0;
  logic [31:0]       p_batch       = 32'd1;
  logic              p_window      = 1'b0;
  logic [31:0]       p_window_high = '0;

  rate_result_t rate_updates_due [$];
  int unsigned  items_accepted = 0;
  int unsigned  errors = 0;
  int unsigned  tx_idle_pct = 15;
  int unsigned  rx_idle_pct = 15;
  int unsigned  hold_requests = 0;
  int unsigned  holds_served = 0;
  int unsigned  stall_left = 0;

  dctcp_ack_rate_control dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic predict_rate_update(input logic [31:0] ack, input logic mark,
                                     input logic [31:0] snd, output rate_result_t res);
    logic [63:0] g, b, frac, cut;
    logic [31:0] span, m, q, sum;
    logic        closed;
    closed = 1'b0;
    if (mark && p_marks != '1) p_marks = p_marks + 1;
    if (ack > p_update_seq) begin
      closed = 1'b1;
      if (p_update_seq == '0) begin
        span = snd;
      end else begin
        g = (cfg_gain > AlphaOne) ? 64'(AlphaOne) : 64'(cfg_gain);
        b = (p_batch == '0) ? 64'd1 : 64'(p_batch);
        frac = (64'(p_marks) >= b) ? 64'(AlphaOne) : (64'(p_marks) << 16) / b;
        p_alpha = AlphaW'(((64'(AlphaOne) - g) * 64'(p_alpha) + g * frac) >> 16);
        p_marks = '0;
        span = snd - ack;
      end
      p_update_seq = snd;
      m = (cfg_mtu == '0) ? 32'd1 : 32'(cfg_mtu);
      q = span / m;
      p_batch = (q == '1) ? q : q + 1;
    end
    if (p_window && ack > p_window_high) p_window = 1'b0;
    if (mark && !p_window) begin
      cut = (64'(p_rate) * (64'(AlphaTwo) - 64'(p_alpha))) >> 17;
      p_rate = (cut < 64'(cfg_min)) ? cfg_min : RateW'(cut);
      p_window = 1'b1;
      p_window_high = snd;
    end
    if (!p_window && closed) begin
      sum = 32'(p_rate) + 32'(cfg_inc);
      p_rate = (sum > 32'(cfg_max)) ? cfg_max : RateW'(sum);
    end
    res = '{p_rate, p_alpha, p_window, closed};
  endtask

  task automatic offer_ack(input logic [31:0] ack, input logic mark, input logic [31:0] snd,
                           input logic use_want, input rate_result_t want);
    rate_result_t res;
    int unsigned  gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ack_sequence_i <= ack;
    congestion_mark_i <= mark;
    send_next_i <= snd;
    do @(posedge clk_i); while (in_stall_o);
    predict_rate_update(ack, mark, snd, res);
    rate_updates_due.push_back(use_want ? want : res);
    items_accepted++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rate_updates_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (reg_idx_e'(idx))
      REG_EWMA_GAIN:     cfg_gain = value[AlphaW-1:0];
      REG_RATE_INCREASE: cfg_inc  = value[RateW-1:0];
      REG_MIN_RATE:      cfg_min  = value[RateW-1:0];
      REG_MAX_RATE:      cfg_max  = value[RateW-1:0];
      REG_MTU_BYTES:     cfg_mtu  = value[MtuW-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : result_sink
    rate_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (rate_updates_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = rate_updates_due.pop_front();
        if (current_rate_o !== want.rate) begin
          $error("current_rate: expected %0d, actual %0d", want.rate, current_rate_o);
          errors++;
        end
        if (alpha_now_o !== want.alpha) begin
          $error("alpha_now: expected %0d, actual %0d", want.alpha, alpha_now_o);
          errors++;
        end
        if (in_reduction_o !== want.window) begin
          $error("in_reduction: expected %0d, actual %0d", want.window, in_reduction_o);
          errors++;
        end
        if (batch_closed_o !== want.closed) begin
          $error("batch_closed: expected %0d, actual %0d", want.closed, batch_closed_o);
          errors++;
        end
      end
    end
    if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      stall_left <= LongHold;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left <= $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    stim_row_t   row;
    logic [31:0] acked, snd, nz;
    logic [31:0] gain_pick, inc_pick, min_pick, max_pick, mtu_pick;
    int unsigned n, target, mtu_eff, mark_pct, phase;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(Directed); i++) begin
      row = Directed[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.a[2:0], row.b);
      end else begin
        offer_ack(row.a, row.mark, row.b, row.has_want, row.want);
      end
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      drain();
      case ($urandom_range(0, 5))
        0: gain_pick = 32'd0;
        1: gain_pick = 32'(AlphaOne);
        2: gain_pick = 32'd131071;
        default: gain_pick = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 4))
        0: inc_pick = 32'd0;
        1: inc_pick = 32'd1000000;
        default: inc_pick = $urandom_range(0, 5000);
      endcase
      case ($urandom_range(0, 5))
        0: min_pick = 32'd0;
        1: min_pick = $urandom_range(0, 1000000);
        default: min_pick = $urandom_range(0, 3000);
      endcase
      case ($urandom_range(0, 4))
        0: max_pick = 32'd1;
        1: max_pick = 32'd1000000;
        default: max_pick = $urandom_range(1000, 200000);
      endcase
      case ($urandom_range(0, 6))
        0: mtu_pick = 32'd0;
        1: mtu_pick = 32'd65535;
        2: mtu_pick = 32'd1;
        default: mtu_pick = $urandom_range(64, 9000);
      endcase
      write_reg(REG_EWMA_GAIN, gain_pick);
      write_reg(REG_RATE_INCREASE, inc_pick);
      write_reg(REG_MIN_RATE, min_pick);
      write_reg(REG_MAX_RATE, max_pick);
      write_reg(REG_MTU_BYTES, mtu_pick);

      if (phase == NumPhases - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end else begin
        tx_idle_pct = 15 * $urandom_range(0, 2);
        rx_idle_pct <= 15 * $urandom_range(0, 2);
      end
      if (phase == 1) hold_requests <= hold_requests + 1;

      target = items_accepted + ItemsPerPhase;
      while (items_accepted < target) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(3, 10)) begin
            nz = $urandom;
            if (&nz) nz = nz - 1;
            offer_ack($urandom, 1'($urandom_range(0, 1)), nz, 1'b0, '0);
          end
        end else begin
          mtu_eff = (cfg_mtu == '0) ? 1 : cfg_mtu;
          acked = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000)
                                              : $urandom_range(1, 32'h7FFF_FFFF);
          mark_pct = $urandom_range(0, 60);
          n = $urandom_range(20, 80);
          repeat (n) begin
            acked = acked + mtu_eff * $urandom_range(0, 3);
            snd = acked + mtu_eff * $urandom_range(0, 16) + $urandom_range(0, mtu_eff - 1);
            offer_ack(acked, $urandom_range(0, 99) < mark_pct, snd, 1'b0, '0);
          end
        end
        // rewind the update point so the next flow arms afresh
        offer_ack(32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, '0);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
